// ===== hdl/can_test_frame_sequence_checker_assert.svh =====
// assertion macros for the can test frame sequence checker
`ifndef CAN_TEST_FRAME_SEQUENCE_CHECKER_ASSERT_SVH
`define CAN_TEST_FRAME_SEQUENCE_CHECKER_ASSERT_SVH

// property checked on every clock edge out of reset
`define CFTSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold
`define CFTSC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/cftsc_pkg.sv =====
// types and constants shared by the can test frame sequence checker
`timescale 1ns / 1ps

package cftsc_pkg;

	typedef struct packed {
		logic        op;
		logic        is_extended;
		logic [28:0] frame_id;
		logic [3:0]  data_length;
		logic [63:0] payload;
	} frame_t;

	typedef struct packed {
		logic [2:0]  frame_class;
		logic [31:0] sequence_number;
		logic [31:0] unknown_total;
		logic [31:0] frame_total;
		logic [31:0] in_order_total;
		logic [31:0] late_total;
		logic [31:0] missed_total;
	} result_t;

	typedef struct packed {
		logic        hit;
		logic        take_expected;
		logic [31:0] seq;
	} match_t;

	localparam logic [1:0] MODE_EVENT = 2'd0;
	localparam logic [1:0] MODE_IDENT = 2'd1;
	localparam logic [1:0] MODE_NODE  = 2'd2;

	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_NODE = 1'b1;

	localparam logic [2:0] CLS_UNKNOWN  = 3'd0;
	localparam logic [2:0] CLS_IN_ORDER = 3'd1;
	localparam logic [2:0] CLS_AHEAD    = 3'd2;
	localparam logic [2:0] CLS_LATE     = 3'd3;
	localparam logic [2:0] CLS_REPORT   = 3'd4;

	localparam logic [28:0] EVENT_ID   = 29'h195b4ffe;
	localparam logic [28:0] IDENT_ID   = 29'h194c7fff;
	localparam logic [28:0] IDENT_MASK = 29'h1fffc000;
	localparam logic [28:0] NODE_HDR   = 29'h19170fff;
	localparam logic [28:0] NODE_MASK  = 29'h1ffff000;
	localparam logic [31:0] PREFIX_WORD = 32'h09000139;
	localparam logic [3:0]  FULL_DLC    = 4'd8;

endpackage

// ===== hdl/cftsc_match.sv =====
// frame recognition under the configured match mode
`timescale 1ns / 1ps

module cftsc_match (
	input  cftsc_pkg::frame_t frame,
	input  logic [1:0]        match_mode,
	input  logic [47:0]       target_node_id,
	output cftsc_pkg::match_t match
);

	logic prefix_ok;

	assign prefix_ok = (frame.data_length == cftsc_pkg::FULL_DLC) &&
		(frame.payload[63:32] == cftsc_pkg::PREFIX_WORD);

	always_comb begin
		match.hit           = 1'b0;
		match.take_expected = 1'b0;
		match.seq           = frame.payload[31:0];
		if (frame.is_extended) begin
			unique case (match_mode)
				cftsc_pkg::MODE_EVENT: begin
					match.hit = (frame.frame_id == cftsc_pkg::EVENT_ID) && prefix_ok;
				end
				cftsc_pkg::MODE_IDENT: begin
					match.hit = ((frame.frame_id & cftsc_pkg::IDENT_MASK) ==
						(cftsc_pkg::IDENT_ID & cftsc_pkg::IDENT_MASK)) && prefix_ok;
				end
				cftsc_pkg::MODE_NODE: begin
					match.hit = ((frame.frame_id & cftsc_pkg::NODE_MASK) ==
						(cftsc_pkg::NODE_HDR & cftsc_pkg::NODE_MASK)) &&
						(frame.payload[63:16] == target_node_id);
					match.take_expected = 1'b1;
				end
				default: begin
					match.hit = 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hdl/cftsc_track.sv =====
// expected sequence number and the five wrapping counters
`timescale 1ns / 1ps

module cftsc_track (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  cftsc_pkg::frame_t   frame,
	input  cftsc_pkg::match_t   match,
	output cftsc_pkg::result_t  result
);

	`include "can_test_frame_sequence_checker_assert.svh"

	logic [31:0] expected_q, unknown_q, frames_q, in_order_q, late_q, missed_q;
	logic [31:0] expected_d, unknown_d, frames_d, in_order_d, late_d, missed_d;
	logic [31:0] seq;

	assign seq = match.take_expected ? expected_q : match.seq;

	always_comb begin
		expected_d = expected_q;
		unknown_d  = unknown_q;
		frames_d   = frames_q;
		in_order_d = in_order_q;
		late_d     = late_q;
		missed_d   = missed_q;
		result.sequence_number = 32'd0;
		result.frame_class     = cftsc_pkg::CLS_UNKNOWN;
		if (frame.op == cftsc_pkg::OP_REPORT) begin
			result.frame_class = cftsc_pkg::CLS_REPORT;
			unknown_d  = 32'd0;
			frames_d   = 32'd0;
			in_order_d = 32'd0;
			late_d     = 32'd0;
			missed_d   = 32'd0;
		end else if (!match.hit) begin
			unknown_d = unknown_q + 32'd1;
		end else begin
			result.sequence_number = seq;
			frames_d = frames_q + 32'd1;
			if (seq == expected_q) begin
				result.frame_class = cftsc_pkg::CLS_IN_ORDER;
				in_order_d = in_order_q + 32'd1;
				expected_d = expected_q + 32'd1;
			end else if (seq > expected_q) begin
				result.frame_class = cftsc_pkg::CLS_AHEAD;
				missed_d   = missed_q + (seq - expected_q);
				expected_d = seq + 32'd1;
			end else begin
				result.frame_class = cftsc_pkg::CLS_LATE;
				late_d = late_q + 32'd1;
			end
		end
		// a report returns the totals as they were before the clear
		if (frame.op == cftsc_pkg::OP_REPORT) begin
			result.unknown_total  = unknown_q;
			result.frame_total    = frames_q;
			result.in_order_total = in_order_q;
			result.late_total     = late_q;
			result.missed_total   = missed_q;
		end else begin
			result.unknown_total  = unknown_d;
			result.frame_total    = frames_d;
			result.in_order_total = in_order_d;
			result.late_total     = late_d;
			result.missed_total   = missed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= 32'd1;
			unknown_q  <= 32'd0;
			frames_q   <= 32'd0;
			in_order_q <= 32'd0;
			late_q     <= 32'd0;
			missed_q   <= 32'd0;
		end else if (adv) begin
			expected_q <= expected_d;
			unknown_q  <= unknown_d;
			frames_q   <= frames_d;
			in_order_q <= in_order_d;
			late_q     <= late_d;
			missed_q   <= missed_d;
		end
	end

	`CFTSC_ASSERT(a_report_clears, adv && frame.op == cftsc_pkg::OP_REPORT |=> unknown_q == 32'd0 && frames_q == 32'd0 && missed_q == 32'd0, "report did not clear counters")
	`CFTSC_ASSERT(a_report_keeps_expected, adv && frame.op == cftsc_pkg::OP_REPORT |=> $stable(expected_q), "report changed expected sequence")
	`CFTSC_ASSERT(a_unknown_counts, adv && frame.op == cftsc_pkg::OP_CHECK && !match.hit |=> unknown_q == $past(unknown_q) + 32'd1, "unknown word not counted")

endmodule

// ===== hdl/can_test_frame_sequence_checker.sv =====
// top level of the can test frame sequence checker
`timescale 1ns / 1ps

// Checks sequence numbers of CAN link-test frames. Each input word is either a
// received frame to check or a request to report the five counters and clear
// them; each produces exactly one result word. A word waits in the input
// register, where it is matched and classified against the expected number,
// and then sits in the result register until taken; a new word can be
// accepted every cycle while result_stall does not hold the result register.
// The rate is set by the single update of the expected number and the
// counters per cycle. Write match_mode and target_node_id only while idle.

module can_test_frame_sequence_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_valid,
	output logic                frame_stall,
	input  cftsc_pkg::frame_t   frame,
	output logic                result_valid,
	input  logic                result_stall,
	output cftsc_pkg::result_t  result,
	input  logic                cfg_write,
	input  logic                cfg_index,
	input  logic [47:0]         cfg_data
);

	`include "can_test_frame_sequence_checker_assert.svh"

	logic [1:0]         match_mode_q;
	logic [47:0]        target_node_id_q;
	logic               valid_s1;
	cftsc_pkg::frame_t  frame_s1;
	logic               adv;
	cftsc_pkg::match_t  match;
	cftsc_pkg::result_t result_d;
	logic               result_valid_q;
	cftsc_pkg::result_t result_q;

	assign adv         = valid_s1 && (!result_valid_q || !result_stall);
	assign frame_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_mode_q     <= cftsc_pkg::MODE_EVENT;
			target_node_id_q <= 48'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cftsc_pkg::CFG_MODE: match_mode_q     <= cfg_data[1:0];
				cftsc_pkg::CFG_NODE: target_node_id_q <= cfg_data;
				default:             match_mode_q     <= match_mode_q;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!frame_stall) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && !frame_stall) begin
			frame_s1 <= frame;
		end
	end

	cftsc_match u_match (
		.frame          (frame_s1),
		.match_mode     (match_mode_q),
		.target_node_id (target_node_id_q),
		.match          (match)
	);

	cftsc_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.frame  (frame_s1),
		.match  (match),
		.result (result_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`CFTSC_NEVER(a_stall_without_word, frame_stall && !valid_s1, "stall raised with empty input stage")
	`CFTSC_ASSERT(a_adv_fills_result, adv |=> result_valid, "word lost between stages")
	`CFTSC_ASSERT(a_unknown_zero_seq, result_valid && (result.frame_class == cftsc_pkg::CLS_UNKNOWN || result.frame_class == cftsc_pkg::CLS_REPORT) |-> result.sequence_number == 32'd0, "sequence number set on unknown or report word")

endmodule
